[hdl/pointer_motion_report_splitter_core_macros.svh]
// Assertion macros for the pointer motion report splitter core.
// Taken in by the top level; each macro expects clk_i and rst_ni in scope.
`ifndef POINTER_MOTION_REPORT_SPLITTER_CORE_MACROS_SVH
`define POINTER_MOTION_REPORT_SPLITTER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PMRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PMRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pmrs_pkg.sv]
// Shared types and constants of the pointer motion report splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package pmrs_pkg;

  // Field widths
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned DELTA_W    = 14;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIM_W      = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STEP_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider operand width: scaled magnitude plus limit rounding fits here
  localparam int unsigned DIV_W = 18;

  // Report count and index sized for the largest supported burst of 64
  localparam int unsigned STEP_CNT_W = 7;
  localparam int unsigned STEP_IDX_W = 6;

  // Q4.12 rounding
  localparam int unsigned GAIN_FRAC = 12;

  // Valid button numbers
  localparam logic [BTN_W-1:0] BTN_FIRST = 3'd1;
  localparam logic [BTN_W-1:0] BTN_LAST  = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET       = 16'd4096;
  localparam logic [LIM_W-1:0]  MOVE_LIM_RESET   = 8'd128;
  localparam logic [LIM_W-1:0]  WHEEL_LIM_RESET  = 8'd120;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_GAIN  = 2'd0,
    CFG_MOVE_LIM   = 2'd1,
    CFG_WHEEL_LIM  = 2'd2
  } cfg_index_e;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_MOVE    = 3'd0,
    REQ_WHEEL   = 3'd1,
    REQ_PRESS   = 3'd2,
    REQ_RELEASE = 3'd3,
    REQ_CLICK   = 3'd4
  } req_type_e;

  // Report kinds on the output
  typedef enum logic [KIND_W-1:0] {
    RPT_MOTION  = 2'd0,
    RPT_WHEEL   = 2'd1,
    RPT_PRESS   = 2'd2,
    RPT_RELEASE = 2'd3
  } report_kind_e;

  // Classified job kinds passed from front to back
  typedef enum logic [2:0] {
    J_MOVE,
    J_WHEEL,
    J_PRESS,
    J_RELEASE,
    J_CLICK,
    J_BAD
  } job_kind_e;

  // Front end sequencer states
  typedef enum logic [3:0] {
    F_IDLE,
    F_SCALE_X,
    F_SCALE_Y,
    F_LIMIT,
    F_CHECK,
    F_DIV_N,
    F_START_X,
    F_DIV_X,
    F_DIV_Y,
    F_PUSH
  } front_state_e;

  // Live configuration
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [LIM_W-1:0]  move_lim;
    logic [LIM_W-1:0]  wheel_lim;
  } cfg_t;

  // One classified job: everything the back end needs to emit its reports
  typedef struct packed {
    job_kind_e               kind;
    logic                    neg_x;
    logic                    neg_y;
    logic [LIM_W-1:0]        base_x;
    logic [STEP_IDX_W-1:0]   rem_x;
    logic [LIM_W-1:0]        base_y;
    logic [STEP_IDX_W-1:0]   rem_y;
    logic [STEP_CNT_W-1:0]   count;
    logic                    clamped;
    logic [BTN_W-1:0]        button;
  } job_t;

  localparam int unsigned JOB_Q_DEPTH = 2;

endpackage

`default_nettype wire

[hdl/pmrs_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on pmrs_pkg for operand widths.
`default_nettype none

module pmrs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pmrs_pkg::DIV_W-1:0]   dividend_i,
  input  logic [pmrs_pkg::LIM_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [pmrs_pkg::DIV_W-1:0]   quotient_o,
  output logic [pmrs_pkg::LIM_W-1:0]   remainder_o
);
  import pmrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [LIM_W-1:0]  rem_q, rem_d;
  logic [LIM_W-1:0]  dsr_q, dsr_d;
  logic [LIM_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and try to subtract
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], fits};
      rem_d = fits ? LIM_W'(trial - {1'b0, dsr_q}) : trial[LIM_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[hdl/pmrs_front.sv]
// Front end: accepts requests, scales motion, sizes the burst and splits shares.
// Depends on pmrs_pkg and pmrs_div; feeds jobs to the job queue.
`default_nettype none

module pmrs_front #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pmrs_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [pmrs_pkg::DELTA_W-1:0] delta_in_x_i,
  input  logic signed [pmrs_pkg::DELTA_W-1:0] delta_in_y_i,
  input  logic [pmrs_pkg::BTN_W-1:0]          button_code_i,
  input  pmrs_pkg::cfg_t                      cfg_i,
  output logic                                push_o,
  input  logic                                full_i,
  output pmrs_pkg::job_t                      job_o
);
  import pmrs_pkg::*;

  localparam int unsigned PROD_W = DELTA_W + GAIN_W;

  // Magnitude of a signed delta; the most negative value maps to its magnitude
  function automatic logic [DELTA_W-1:0] abs_delta(input logic signed [DELTA_W-1:0] v);
    logic [DELTA_W-1:0] r;
    r = v[DELTA_W-1] ? DELTA_W'(~v + DELTA_W'(1)) : v;
    return r;
  endfunction

  front_state_e             state_q, state_d;
  job_kind_e                kind_q, kind_d;
  logic [DELTA_W-1:0]       x_q, x_d;
  logic [DELTA_W-1:0]       y_q, y_d;
  logic [BTN_W-1:0]         btn_q, btn_d;
  logic [DIV_W-1:0]         mx_q, mx_d;
  logic [DIV_W-1:0]         my_q, my_d;
  logic [DIV_W-1:0]         mmax_q, mmax_d;
  logic [DIV_W-1:0]         cap_q, cap_d;
  logic [LIM_W-1:0]         lim_q, lim_d;
  logic [STEP_CNT_W-1:0]    n_q, n_d;
  logic                     clamp_q, clamp_d;
  logic [LIM_W-1:0]         bx_q, bx_d;
  logic [LIM_W-1:0]         by_q, by_d;
  logic [STEP_IDX_W-1:0]    rx_q, rx_d;
  logic [STEP_IDX_W-1:0]    ry_q, ry_d;

  logic [DELTA_W-1:0]       mul_in;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod_rnd;
  logic [DIV_W-1:0]         scaled;
  logic [LIM_W-1:0]         lim_sel;
  logic [LIM_W-1:0]         lim_eff;
  logic                     btn_ok;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [LIM_W-1:0]         div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [LIM_W-1:0]         div_rem;

  // Share one multiplier between the two axes
  assign mul_in   = (state_q == F_SCALE_X) ? abs_delta(x_q) : abs_delta(y_q);
  assign prod     = PROD_W'(mul_in) * PROD_W'(cfg_i.gain);
  assign prod_rnd = prod + PROD_W'(1 << (GAIN_FRAC - 1));
  assign scaled   = prod_rnd[PROD_W-1:GAIN_FRAC];

  // Pick the limit of this request; treat zero as one
  assign lim_sel = (kind_q == J_WHEEL) ? cfg_i.wheel_lim : cfg_i.move_lim;
  assign lim_eff = (lim_sel == '0) ? LIM_W'(1) : lim_sel;

  assign btn_ok = (button_code_i >= BTN_FIRST) && (button_code_i <= BTN_LAST);

  pmrs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequence one request through scale, size and split
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    x_d          = x_q;
    y_d          = y_q;
    btn_d        = btn_q;
    mx_d         = mx_q;
    my_d         = my_q;
    mmax_d       = mmax_q;
    cap_d        = cap_q;
    lim_d        = lim_q;
    n_d          = n_q;
    clamp_d      = clamp_q;
    bx_d         = bx_q;
    by_d         = by_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    div_start    = 1'b0;
    div_dividend = mx_q;
    div_divisor  = lim_q;
    push_o       = 1'b0;

    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          x_d     = delta_in_x_i;
          y_d     = delta_in_y_i;
          btn_d   = button_code_i;
          clamp_d = 1'b0;
          n_d     = STEP_CNT_W'(1);
          case (req_type_i)
            REQ_MOVE: begin
              kind_d  = J_MOVE;
              state_d = F_SCALE_X;
            end
            REQ_WHEEL: begin
              kind_d  = J_WHEEL;
              mx_d    = DIV_W'(abs_delta(delta_in_x_i));
              my_d    = '0;
              state_d = F_LIMIT;
            end
            REQ_PRESS, REQ_RELEASE, REQ_CLICK: begin
              state_d = F_PUSH;
              if (!btn_ok) begin
                kind_d = J_BAD;
              end else if (req_type_i == REQ_PRESS) begin
                kind_d = J_PRESS;
              end else if (req_type_i == REQ_RELEASE) begin
                kind_d = J_RELEASE;
              end else begin
                kind_d = J_CLICK;
                n_d    = STEP_CNT_W'(2);
              end
            end
            default: begin
              // Drop unknown requests
              state_d = F_IDLE;
            end
          endcase
        end
      end
      F_SCALE_X: begin
        mx_d    = scaled;
        state_d = F_SCALE_Y;
      end
      F_SCALE_Y: begin
        my_d    = scaled;
        state_d = F_LIMIT;
      end
      F_LIMIT: begin
        lim_d   = lim_eff;
        cap_d   = DIV_W'(MAX_STEPS * lim_eff);
        mmax_d  = (mx_q > my_q) ? mx_q : my_q;
        state_d = F_CHECK;
      end
      F_CHECK: begin
        if (mmax_q > cap_q) begin
          // Too many reports: saturate both axes and use the full burst
          clamp_d = 1'b1;
          n_d     = STEP_CNT_W'(MAX_STEPS);
          mx_d    = (mx_q > cap_q) ? cap_q : mx_q;
          my_d    = (my_q > cap_q) ? cap_q : my_q;
          state_d = F_START_X;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(mmax_q + DIV_W'(lim_q) - DIV_W'(1));
          div_divisor  = lim_q;
          state_d      = F_DIV_N;
        end
      end
      F_DIV_N: begin
        if (div_done) begin
          // Zero motion still makes one report
          n_d     = (div_quo == '0) ? STEP_CNT_W'(1) : div_quo[STEP_CNT_W-1:0];
          state_d = F_START_X;
        end
      end
      F_START_X: begin
        div_start    = 1'b1;
        div_dividend = mx_q;
        div_divisor  = LIM_W'(n_q);
        state_d      = F_DIV_X;
      end
      F_DIV_X: begin
        div_dividend = my_q;
        div_divisor  = LIM_W'(n_q);
        if (div_done) begin
          bx_d      = div_quo[LIM_W-1:0];
          rx_d      = div_rem[STEP_IDX_W-1:0];
          div_start = 1'b1;
          state_d   = F_DIV_Y;
        end
      end
      F_DIV_Y: begin
        if (div_done) begin
          by_d    = div_quo[LIM_W-1:0];
          ry_d    = div_rem[STEP_IDX_W-1:0];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the working values of the current request
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    x_q     <= x_d;
    y_q     <= y_d;
    btn_q   <= btn_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    mmax_q  <= mmax_d;
    cap_q   <= cap_d;
    lim_q   <= lim_d;
    n_q     <= n_d;
    clamp_q <= clamp_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
  end

  assign in_stall_o = (state_q != F_IDLE);

  // Assemble the job for the queue
  always_comb begin
    job_o.kind    = kind_q;
    job_o.neg_x   = x_q[DELTA_W-1];
    job_o.neg_y   = y_q[DELTA_W-1];
    job_o.base_x  = bx_q;
    job_o.rem_x   = rx_q;
    job_o.base_y  = by_q;
    job_o.rem_y   = ry_q;
    job_o.count   = n_q;
    job_o.clamped = clamp_q;
    job_o.button  = btn_q;
  end

endmodule

`default_nettype wire

[hdl/pmrs_fifo.sv]
// Two-entry job queue between front and back ends.
// Depends on pmrs_pkg for the job type and depth.
`default_nettype none

module pmrs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pmrs_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pmrs_pkg::job_t  job_o
);
  import pmrs_pkg::*;

  localparam int unsigned PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(JOB_Q_DEPTH + 1);

  job_t              mem_q [JOB_Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CNT_W'(JOB_Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store a pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[hdl/pmrs_back.sv]
// Back end: takes jobs from the queue and emits their reports one per cycle while the output is not stalled.
// Depends on pmrs_pkg; drives the registered output channel.
`default_nettype none

module pmrs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  pmrs_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pmrs_pkg::KIND_W-1:0]        report_kind_o,
  output logic signed [pmrs_pkg::STEP_W-1:0] step_x_o,
  output logic signed [pmrs_pkg::STEP_W-1:0] step_y_o,
  output logic signed [pmrs_pkg::STEP_W-1:0] wheel_step_o,
  output logic [pmrs_pkg::BTN_W-1:0]         which_button_o,
  output logic                               last_report_o,
  output logic                               bad_button_o,
  output logic                               clamped_o
);
  import pmrs_pkg::*;

  logic                    active_q, active_d;
  job_t                    job_q, job_d;
  logic [STEP_IDX_W-1:0]   idx_q, idx_d;
  logic                    ovalid_q, ovalid_d;
  report_kind_e            kind_q, kind_d;
  logic [STEP_W-1:0]       sx_q, sx_d;
  logic [STEP_W-1:0]       sy_q, sy_d;
  logic [STEP_W-1:0]       wh_q, wh_d;
  logic [BTN_W-1:0]        btn_q, btn_d;
  logic                    last_q, last_d;
  logic                    bad_q, bad_d;
  logic                    clp_q, clp_d;

  logic                    load_out;
  logic [STEP_W-1:0]       mag_x, mag_y;
  logic [STEP_W-1:0]       val_x, val_y;
  logic                    is_last;

  assign load_out = !ovalid_q || !out_stall_i;
  assign pop_o    = !active_q && !empty_i;

  // Base share plus one extra count for the leading reports, then the sign
  assign mag_x   = STEP_W'(job_q.base_x) + STEP_W'(idx_q < job_q.rem_x);
  assign mag_y   = STEP_W'(job_q.base_y) + STEP_W'(idx_q < job_q.rem_y);
  assign val_x   = job_q.neg_x ? STEP_W'(-mag_x) : mag_x;
  assign val_y   = job_q.neg_y ? STEP_W'(-mag_y) : mag_y;
  assign is_last = ((STEP_CNT_W'(idx_q) + STEP_CNT_W'(1)) == job_q.count);

  always_comb begin
    active_d = active_q;
    job_d    = job_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    kind_d   = kind_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    wh_d     = wh_q;
    btn_d    = btn_q;
    last_d   = last_q;
    bad_d    = bad_q;
    clp_d    = clp_q;

    // Take the next job when free
    if (pop_o) begin
      active_d = 1'b1;
      job_d    = job_i;
      idx_d    = '0;
    end

    if (load_out) begin
      ovalid_d = 1'b0;
      if (active_q) begin
        ovalid_d = 1'b1;
        kind_d   = RPT_MOTION;
        sx_d     = '0;
        sy_d     = '0;
        wh_d     = '0;
        btn_d    = '0;
        last_d   = is_last;
        bad_d    = 1'b0;
        clp_d    = 1'b0;
        case (job_q.kind)
          J_MOVE: begin
            sx_d  = val_x;
            sy_d  = val_y;
            clp_d = job_q.clamped;
          end
          J_WHEEL: begin
            kind_d = RPT_WHEEL;
            wh_d   = val_x;
            clp_d  = job_q.clamped;
          end
          J_PRESS: begin
            kind_d = RPT_PRESS;
            btn_d  = job_q.button;
          end
          J_RELEASE: begin
            kind_d = RPT_RELEASE;
            btn_d  = job_q.button;
          end
          J_CLICK: begin
            kind_d = (idx_q == '0) ? RPT_PRESS : RPT_RELEASE;
            btn_d  = job_q.button;
          end
          default: begin
            // Bad button: one error result, all else zero
            bad_d = 1'b1;
          end
        endcase
        // Advance through the burst or drop the finished job
        if (is_last) begin
          active_d = 1'b0;
        end else begin
          idx_d = idx_q + STEP_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Hold the job and the output payload
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    idx_q  <= idx_d;
    kind_q <= kind_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    wh_q   <= wh_d;
    btn_q  <= btn_d;
    last_q <= last_d;
    bad_q  <= bad_d;
    clp_q  <= clp_d;
  end

  assign out_valid_o    = ovalid_q;
  assign report_kind_o  = kind_q;
  assign step_x_o       = sx_q;
  assign step_y_o       = sy_q;
  assign wheel_step_o   = wh_q;
  assign which_button_o = btn_q;
  assign last_report_o  = last_q;
  assign bad_button_o   = bad_q;
  assign clamped_o      = clp_q;

endmodule

`default_nettype wire

[hdl/pointer_motion_report_splitter_core.sv]
// Pointer motion report splitter. A move request is scaled by the Q4.12 gain
// and split into up to MAX_STEPS motion reports; a wheel request is split the
// same way with its own limit; press, release and click requests give one or
// two button reports, and a bad button number gives one error result. The
// front end holds one request at a time. A move is scaled in one shared
// multiplier, one axis at a time, then takes three passes of the serial
// divider (burst size, x share, y share). A clamped move skips the
// burst-size pass. A wheel skips the multiplier. A full job queue holds the
// front end in its push step. The back end emits one report per cycle while
// the output is not stalled, from a two-entry job queue, and takes the next
// job only after the last report of the current one, so the front end works
// on the next request while a burst is going out. A report waits in the
// output register while out_stall_i is high. Configuration writes are always
// accepted (cfg_ready_o is always high).
// Depends on pmrs_pkg, pmrs_front, pmrs_div, pmrs_fifo and pmrs_back.
`default_nettype none

`include "pointer_motion_report_splitter_core_macros.svh"

module pointer_motion_report_splitter_core #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pmrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pmrs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pmrs_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [pmrs_pkg::DELTA_W-1:0] delta_in_x_i,
  input  logic signed [pmrs_pkg::DELTA_W-1:0] delta_in_y_i,
  input  logic [pmrs_pkg::BTN_W-1:0]          button_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pmrs_pkg::KIND_W-1:0]         report_kind_o,
  output logic signed [pmrs_pkg::STEP_W-1:0]  step_x_o,
  output logic signed [pmrs_pkg::STEP_W-1:0]  step_y_o,
  output logic signed [pmrs_pkg::STEP_W-1:0]  wheel_step_o,
  output logic [pmrs_pkg::BTN_W-1:0]          which_button_o,
  output logic                                last_report_o,
  output logic                                bad_button_o,
  output logic                                clamped_o
);
  import pmrs_pkg::*;

  cfg_t  cfg_q, cfg_d;
  job_t  fe_job;
  job_t  q_job;
  logic  fe_push;
  logic  q_full;
  logic  q_empty;
  logic  be_pop;

  assign cfg_ready_o = 1'b1;

  // Update the addressed register; ignore unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MOVE_GAIN: cfg_d.gain      = cfg_data_i[GAIN_W-1:0];
        CFG_MOVE_LIM:  cfg_d.move_lim  = cfg_data_i[LIM_W-1:0];
        CFG_WHEEL_LIM: cfg_d.wheel_lim = cfg_data_i[LIM_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain      <= GAIN_RESET;
      cfg_q.move_lim  <= MOVE_LIM_RESET;
      cfg_q.wheel_lim <= WHEEL_LIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pmrs_front #(
    .MAX_STEPS (MAX_STEPS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .delta_in_x_i  (delta_in_x_i),
    .delta_in_y_i  (delta_in_y_i),
    .button_code_i (button_code_i),
    .cfg_i         (cfg_q),
    .push_o        (fe_push),
    .full_i        (q_full),
    .job_o         (fe_job)
  );

  pmrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .job_i   (fe_job),
    .full_o  (q_full),
    .pop_i   (be_pop),
    .empty_o (q_empty),
    .job_o   (q_job)
  );

  pmrs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .job_i          (q_job),
    .pop_o          (be_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_kind_o  (report_kind_o),
    .step_x_o       (step_x_o),
    .step_y_o       (step_y_o),
    .wheel_step_o   (wheel_step_o),
    .which_button_o (which_button_o),
    .last_report_o  (last_report_o),
    .bad_button_o   (bad_button_o),
    .clamped_o      (clamped_o)
  );

  // Front never pushes into a full queue
  `PMRS_ASSERT_NOW(a_push_not_full, fe_push, !q_full, "job pushed into full queue")
  // Back never pops an empty queue
  `PMRS_ASSERT_NOW(a_pop_not_empty, be_pop, !q_empty, "job popped from empty queue")
  // An error result is final and carries no button
  `PMRS_ASSERT_NOW(a_bad_is_last, out_valid_o && bad_button_o,
                   last_report_o && (which_button_o == '0) && !clamped_o,
                   "bad button result malformed")
  // Clamping only marks motion or wheel reports
  `PMRS_ASSERT_NOW(a_clamp_kind, out_valid_o && clamped_o,
                   (report_kind_o == RPT_MOTION) || (report_kind_o == RPT_WHEEL),
                   "clamped flag on a button report")

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for pointer_motion_report_splitter_core: drives move, wheel and
// button requests across several register settings and checks every report in order.
// Depends on pmrs_pkg and the RTL of the core only.
`default_nettype none

module testbench;
  import pmrs_pkg::*;

  localparam int unsigned MAX_STEPS       = 64;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PRINT_LIMIT     = 100;
  localparam int unsigned PAD_W           = CFG_DATA_W - LIM_W;
  localparam int          DELTA_MAX       = (1 << (DELTA_W - 1)) - 1;
  localparam int          DELTA_MIN       = -(1 << (DELTA_W - 1));
  localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_W'(REQ_CLICK + 1);
  localparam logic [REQ_W-1:0] REQ_TOP          = '1;
  localparam logic [BTN_W-1:0] BTN_NONE         = '0;
  localparam logic [BTN_W-1:0] BTN_TOP          = '1;
  localparam logic [BTN_W-1:0] BTN_MIDDLE       = 3'd3;

  typedef struct {
    report_kind_e             kind;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic signed [STEP_W-1:0] wheel_step;
    logic [BTN_W-1:0]         button;
    logic                     last;
    logic                     bad;
    logic                     clamped;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [REQ_W-1:0] req_type_i;
  logic signed [DELTA_W-1:0] delta_in_x_i;
  logic signed [DELTA_W-1:0] delta_in_y_i;
  logic [BTN_W-1:0] button_code_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [KIND_W-1:0] report_kind_o;
  logic signed [STEP_W-1:0] step_x_o;
  logic signed [STEP_W-1:0] step_y_o;
  logic signed [STEP_W-1:0] wheel_step_o;
  logic [BTN_W-1:0] which_button_o;
  logic last_report_o;
  logic bad_button_o;
  logic clamped_o;

  // Shadow copy of the registers
  logic [GAIN_W-1:0] gain_q      = GAIN_RESET;
  logic [LIM_W-1:0]  move_lim_q  = MOVE_LIM_RESET;
  logic [LIM_W-1:0]  wheel_lim_q = WHEEL_LIM_RESET;

  report_t pending_reports[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  pointer_motion_report_splitter_core #(
    .MAX_STEPS(MAX_STEPS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .delta_in_x_i   (delta_in_x_i),
    .delta_in_y_i   (delta_in_y_i),
    .button_code_i  (button_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .report_kind_o  (report_kind_o),
    .step_x_o       (step_x_o),
    .step_y_o       (step_y_o),
    .wheel_step_o   (wheel_step_o),
    .which_button_o (which_button_o),
    .last_report_o  (last_report_o),
    .bad_button_o   (bad_button_o),
    .clamped_o      (clamped_o)
  );

  // Generate the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one line per mismatch, up to a cap, and count all of them
  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) $display("%0t: ERROR %s", $time, msg);
    error_count++;
  endtask

  // ------------------------------------------------------------------
  // Report prediction
  // ------------------------------------------------------------------

  function automatic void push_report(report_kind_e kind, int sx, int sy, int wh,
                                      logic [BTN_W-1:0] btn, logic last, logic bad,
                                      logic clp);
    report_t r;
    r.kind       = kind;
    r.step_x     = STEP_W'(sx);
    r.step_y     = STEP_W'(sy);
    r.wheel_step = STEP_W'(wh);
    r.button     = btn;
    r.last       = last;
    r.bad        = bad;
    r.clamped    = clp;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // Apply the Q4.12 gain to a magnitude, rounding half away from zero
  function automatic int unsigned scaled_magnitude(int v);
    int unsigned m;
    m = (v < 0) ? -v : v;
    return (m * gain_q + (1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
  endfunction

  // Split signed magnitudes into a burst of equal-share reports
  function automatic void split_burst(bit neg_x, int unsigned mag_x, bit neg_y,
                                      int unsigned mag_y, logic [LIM_W-1:0] limit_raw,
                                      bit is_wheel);
    int unsigned lim, n, n_y, cap, bx, rx, by, ry, i;
    int sx, sy;
    bit clp;
    lim = (limit_raw == 0) ? 1 : limit_raw;
    clp = 1'b0;
    n   = (mag_x + lim - 1) / lim;
    n_y = (mag_y + lim - 1) / lim;
    if (n_y > n) n = n_y;
    if (n < 1) n = 1;
    // Clamp an oversized burst and saturate both axes
    if (n > MAX_STEPS) begin
      n   = MAX_STEPS;
      cap = MAX_STEPS * lim;
      if (mag_x > cap) mag_x = cap;
      if (mag_y > cap) mag_y = cap;
      clp = 1'b1;
    end
    bx = mag_x / n;
    rx = mag_x % n;
    by = mag_y / n;
    ry = mag_y % n;
    for (i = 0; i < n; i++) begin
      sx = bx + ((i < rx) ? 1 : 0);
      sy = by + ((i < ry) ? 1 : 0);
      if (neg_x) sx = -sx;
      if (neg_y) sy = -sy;
      if (is_wheel) push_report(RPT_WHEEL, 0, 0, sx, BTN_NONE, i + 1 == n, 1'b0, clp);
      else push_report(RPT_MOTION, sx, sy, 0, BTN_NONE, i + 1 == n, 1'b0, clp);
    end
  endfunction

  function automatic void split_request(logic [REQ_W-1:0] kind, int x, int y,
                                        logic [BTN_W-1:0] btn);
    bit btn_ok;
    btn_ok = (btn >= BTN_FIRST) && (btn <= BTN_LAST);
    case (kind)
      REQ_MOVE: begin
        split_burst(x < 0, scaled_magnitude(x), y < 0, scaled_magnitude(y), move_lim_q,
                    1'b0);
      end
      REQ_WHEEL: begin
        split_burst(x < 0, (x < 0) ? -x : x, 1'b0, 0, wheel_lim_q, 1'b1);
      end
      REQ_PRESS, REQ_RELEASE, REQ_CLICK: begin
        // A bad button gives one error result with every other field zero
        if (!btn_ok) push_report(RPT_MOTION, 0, 0, 0, BTN_NONE, 1'b1, 1'b1, 1'b0);
        else if (kind == REQ_PRESS) push_report(RPT_PRESS, 0, 0, 0, btn, 1'b1, 1'b0, 1'b0);
        else if (kind == REQ_RELEASE) begin
          push_report(RPT_RELEASE, 0, 0, 0, btn, 1'b1, 1'b0, 1'b0);
        end else begin
          push_report(RPT_PRESS, 0, 0, 0, btn, 1'b0, 1'b0, 1'b0);
          push_report(RPT_RELEASE, 0, 0, 0, btn, 1'b1, 1'b0, 1'b0);
        end
      end
      default: ; // unknown request codes give nothing
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Report checking and watchdog
  // ------------------------------------------------------------------

  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_error($sformatf("unexpected report kind %0d", report_kind_o));
      end else begin
        want = pending_reports.pop_front();
        if (report_kind_o !== want.kind)
          report_error($sformatf("report_kind got %0d want %0d", report_kind_o, want.kind));
        if (step_x_o !== want.step_x)
          report_error($sformatf("step_x got %0d want %0d", step_x_o, want.step_x));
        if (step_y_o !== want.step_y)
          report_error($sformatf("step_y got %0d want %0d", step_y_o, want.step_y));
        if (wheel_step_o !== want.wheel_step)
          report_error($sformatf("wheel_step got %0d want %0d", wheel_step_o,
                                 want.wheel_step));
        if (which_button_o !== want.button)
          report_error($sformatf("which_button got %0d want %0d", which_button_o,
                                 want.button));
        if (last_report_o !== want.last)
          report_error($sformatf("last_report got %0b want %0b", last_report_o, want.last));
        if (bad_button_o !== want.bad)
          report_error($sformatf("bad_button got %0b want %0b", bad_button_o, want.bad));
        if (clamped_o !== want.clamped)
          report_error($sformatf("clamped got %0b want %0b", clamped_o, want.clamped));
      end
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pointer_motion_report_splitter_core test failed");
      $finish;
    end
  end

  // Stall the output with short bursts, a few long ones and free-running stretches
  initial begin : stall_gen
    int sel;
    int run;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        out_stall_i = 1'b0;
        run = $urandom_range(1, 4);
      end else if (sel < 6) begin
        out_stall_i = 1'b1;
        run = $urandom_range(1, 3);
      end else if (sel == 6) begin
        out_stall_i = 1'b1;
        run = $urandom_range(10, 40);
      end else begin
        out_stall_i = 1'b0;
        run = $urandom_range(20, 120);
      end
      repeat (run) @(negedge clk_i);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    if (sel < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Send one item; hold it until accepted, then predict its reports
  task automatic send_request(input logic [REQ_W-1:0] kind, input int x, input int y,
                              input logic [BTN_W-1:0] btn);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = kind;
    delta_in_x_i  = x[DELTA_W-1:0];
    delta_in_y_i  = y[DELTA_W-1:0];
    button_code_i = btn;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    split_request(kind, x, y, btn);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending report, then let the core settle
  task automatic wait_for_idle(input int unsigned settle);
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_MOVE_GAIN: gain_q      = value;
      CFG_MOVE_LIM:  move_lim_q  = value[LIM_W-1:0];
      CFG_WHEEL_LIM: wheel_lim_q = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Junk in the unused upper bits of a limit write half the time
  function automatic logic [CFG_DATA_W-LIM_W-1:0] limit_pad();
    return ($urandom_range(0, 1) == 0) ? '0 : PAD_W'($urandom());
  endfunction

  task automatic write_settings(input logic [GAIN_W-1:0] gain, input logic [LIM_W-1:0] mlim,
                                input logic [LIM_W-1:0] wlim);
    wait_for_idle(SETTLE_CYCLES);
    write_register(CFG_MOVE_GAIN, gain);
    write_register(CFG_MOVE_LIM, {limit_pad(), mlim});
    write_register(CFG_WHEEL_LIM, {limit_pad(), wlim});
  endtask

  function automatic int rand_delta();
    int sel;
    int mag;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: return int'($urandom_range(0, (1 << DELTA_W) - 1)) + DELTA_MIN;
      2: begin
        case ($urandom_range(0, 4))
          0: return DELTA_MIN;
          1: return DELTA_MAX;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      3, 4, 5, 6: mag = $urandom_range(0, 300);
      default: mag = $urandom_range(0, 2000);
    endcase
    return ($urandom_range(0, 1) == 0) ? mag : -mag;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel < 5) return GAIN_W'($urandom_range(GAIN_RESET / 2, GAIN_RESET * 2));
    return GAIN_W'($urandom());
  endfunction

  function automatic logic [LIM_W-1:0] rand_limit();
    if ($urandom_range(0, 9) < 3) return LIM_W'($urandom_range(1, 8));
    return LIM_W'($urandom_range(1, 255));
  endfunction

  task automatic send_random_request();
    int sel;
    logic [REQ_W-1:0] kind;
    logic [BTN_W-1:0] btn;
    sel = $urandom_range(0, 19);
    if (sel < 8) kind = REQ_MOVE;
    else if (sel < 12) kind = REQ_WHEEL;
    else if (sel < 14) kind = REQ_PRESS;
    else if (sel < 16) kind = REQ_RELEASE;
    else if (sel < 19) kind = REQ_CLICK;
    else kind = REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_TOP));
    if ($urandom_range(0, 6) == 0) btn = BTN_W'($urandom());
    else btn = BTN_W'($urandom_range(BTN_FIRST, BTN_LAST));
    send_request(kind, rand_delta(), rand_delta(), btn);
  endtask

  task automatic send_random_batch(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      // Hold off now and then until the core has emptied
      if ($urandom_range(0, 39) == 0) wait_for_idle(0);
      send_random_request();
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Split moves and wheel turns at the reset register values
  task automatic test_reset_motion();
    send_request(REQ_MOVE, 0, 0, BTN_NONE);
    send_request(REQ_MOVE, DELTA_MAX, DELTA_MIN, BTN_NONE);
    send_request(REQ_MOVE, DELTA_MIN, DELTA_MAX, BTN_TOP);
    send_request(REQ_MOVE, MOVE_LIM_RESET, -(MOVE_LIM_RESET + 1), BTN_NONE);
    send_request(REQ_MOVE, 1, -1, BTN_NONE);
    send_request(REQ_WHEEL, 0, DELTA_MAX, BTN_NONE);
    send_request(REQ_WHEEL, DELTA_MIN, 0, BTN_NONE);
    send_request(REQ_WHEEL, DELTA_MAX, DELTA_MIN, BTN_NONE);
    send_request(REQ_WHEEL, WHEEL_LIM_RESET + 1, 0, BTN_NONE);
  endtask

  // Press, release and click, bad button numbers and unknown request codes
  task automatic test_buttons();
    int t;
    send_request(REQ_PRESS, 0, 0, BTN_FIRST);
    send_request(REQ_RELEASE, 0, 0, BTN_LAST);
    send_request(REQ_CLICK, 0, 0, BTN_MIDDLE);
    send_request(REQ_PRESS, 0, 0, BTN_NONE);
    send_request(REQ_RELEASE, DELTA_MIN, DELTA_MAX, BTN_LAST + 1);
    send_request(REQ_CLICK, DELTA_MAX, DELTA_MIN, BTN_TOP);
    for (t = REQ_FIRST_UNUSED; t <= REQ_TOP; t++) begin
      send_request(REQ_W'(t), DELTA_MAX, DELTA_MIN, BTN_FIRST);
    end
  endtask

  // Largest gain and limits: full-range moves clamp
  task automatic test_high_extremes();
    write_settings('1, '1, '1);
    send_request(REQ_MOVE, DELTA_MAX, DELTA_MIN, BTN_NONE);
    send_request(REQ_MOVE, 1, -1, BTN_NONE);
    send_random_batch(50);
  endtask

  // Zero gain and unit limits
  task automatic test_low_extremes();
    write_settings('0, 8'd1, 8'd1);
    send_request(REQ_MOVE, DELTA_MAX, DELTA_MIN, BTN_NONE);
    send_random_batch(40);
  endtask

  // A zero limit acts as a limit of one
  task automatic test_zero_limit();
    write_settings(rand_gain(), '0, '0);
    send_random_batch(40);
  endtask

  task automatic test_random_settings();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      write_settings(rand_gain(), rand_limit(), rand_limit());
      send_random_batch(60);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MOVE_GAIN;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_MOVE;
    delta_in_x_i  = '0;
    delta_in_y_i  = '0;
    button_code_i = BTN_NONE;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_motion();
    test_buttons();
    test_high_extremes();
    test_low_extremes();
    test_zero_limit();
    test_random_settings();

    wait_for_idle(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("pointer_motion_report_splitter_core test passed");
    end else begin
      $display("pointer_motion_report_splitter_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
